// ===== sv/bcpe_pkg.sv =====
// Package for the Bezier curve point evaluator: item structs, widths and constants.
// Depends on nothing; every file but bcpe_ram imports it.
`default_nettype none
package bcpe_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ParamW = 17;
  localparam int unsigned IdxW = 4;
  localparam int unsigned DegW = 4;
  localparam logic [ParamW-1:0] ParamOne = 17'd65536;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IdxW-1:0]   point_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [ParamW-1:0] curve_param;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } rsp_t;

  // queued command from front to back
  typedef struct packed {
    logic              is_eval;
    logic [DegW-1:0]   degree;
    logic [ParamW-1:0] t;
  } cmd_t;

  // binomial C(n,i), n up to 15
  function automatic logic [12:0] binom(input logic [3:0] n, input logic [3:0] i);
    logic [12:0] c;
    c = 13'd1;
    for (int k = 0; k < 16; k++) begin
      if (k < int'(i)) c = 13'((32'(c) * 32'(int'(n) - k)) / 32'(k + 1));
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== sv/bcpe_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bcpe_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/bcpe_front.sv =====
// Front end: accepts items, writes loads into the point store, queues evaluations.
// Depends on bcpe_pkg.
`default_nettype none
module bcpe_front #(
  parameter int unsigned MaxPoints = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire bcpe_pkg::req_t              in_data_i,
  input  wire logic [bcpe_pkg::DegW-1:0]   degree_i,
  output logic                             we_o,
  output logic [$clog2(MaxPoints)-1:0]     waddr_o,
  output logic [3*bcpe_pkg::CoordW-1:0]    wdata_o,
  output logic                             cmd_valid_o,
  input  wire logic                        cmd_ready_i,
  output bcpe_pkg::cmd_t                   cmd_o
);
  import bcpe_pkg::*;
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam logic [DegW-1:0] MaxDeg = DegW'(MaxPoints - 1);

  logic [DegW-1:0] n_eff;
  logic cmd_v_q;
  cmd_t cmd_q;
  logic acc;

  assign n_eff = (degree_i > MaxDeg) ? MaxDeg : degree_i;
  // one-entry queue; a load waits until no evaluation is queued or running
  assign in_ready_o = (in_data_i.req_type == REQ_LOAD) ? (!cmd_v_q && cmd_ready_i)
                                                        : (!cmd_v_q || cmd_ready_i);
  assign acc = in_valid_i && in_ready_o;
  assign we_o = acc && (in_data_i.req_type == REQ_LOAD) && (in_data_i.point_index <= n_eff);
  assign waddr_o = in_data_i.point_index[AW-1:0];
  assign wdata_o = {in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
  assign cmd_valid_o = cmd_v_q;
  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
    end else if (acc && in_data_i.req_type == REQ_EVAL) begin
      cmd_v_q <= 1'b1;
    end else if (cmd_ready_i) begin
      cmd_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.req_type == REQ_EVAL) begin
      cmd_q.is_eval <= 1'b1;
      cmd_q.degree  <= n_eff;
      cmd_q.t       <= (in_data_i.curve_param > ParamOne) ? ParamOne : in_data_i.curve_param;
    end
  end
endmodule
`default_nettype wire

// ===== sv/bcpe_back.sv =====
// Back end: power tables, then one control point per step through a shared datapath.
// Depends on bcpe_pkg; reads the point store through its registered port.
`default_nettype none
module bcpe_back #(
  parameter int unsigned MaxPoints = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  output logic                           cmd_ready_o,
  input  wire bcpe_pkg::cmd_t            cmd_i,
  output logic [$clog2(MaxPoints)-1:0]   raddr_o,
  input  wire logic [3*bcpe_pkg::CoordW-1:0] rdata_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bcpe_pkg::rsp_t                 out_data_o
);
  import bcpe_pkg::*;
  localparam int unsigned AW = $clog2(MaxPoints);

  typedef enum logic [2:0] {S_IDLE, S_POW, S_BL0, S_BL1, S_ACC, S_DONE} state_e;

  state_e state_q;
  logic [DegW-1:0] n_q, i_q;
  logic [DegW:0] k_q;
  logic [ParamW-1:0] t_q, u_q;
  logic [ParamW-1:0] tp_q [MaxPoints];
  logic [ParamW-1:0] up_q [MaxPoints];
  logic [ParamW-1:0] tpk_q, upk_q, ti, ui;
  logic [29:0] cb_q;
  logic [ParamW-1:0] blend_q;
  logic signed [40:0] ax_q, ay_q, az_q;
  logic [33:0] tprod, uprod;
  logic [46:0] bprod;
  logic signed [CoordW-1:0] cx, cy, cz;
  logic last_q;
  rsp_t out_q;
  logic ov_q;
  logic [12:0] binom_tab [16][16];

  // constant binomial table, indexed by degree and point
  for (genvar gn = 0; gn < 16; gn++) begin : g_bn
    for (genvar gi = 0; gi < 16; gi++) begin : g_bi
      assign binom_tab[gn][gi] = binom(4'(gn), 4'(gi));
    end
  end

  function automatic logic signed [CoordW-1:0] sat(input logic signed [40:0] a);
    logic signed [24:0] s;
    s = a[40:16];
    if (s > 25'sd32767) return 16'sh7fff;
    if (s < -25'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  assign tprod = 34'(tpk_q) * 34'(t_q);
  assign uprod = 34'(upk_q) * 34'(u_q);
  assign ti = tp_q[i_q[AW-1:0]];
  assign ui = up_q[AW'(n_q - i_q)];
  assign bprod = 47'(cb_q) * 47'(ui);
  assign raddr_o = i_q[AW-1:0];
  assign {cx, cy, cz} = rdata_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          state_q <= S_POW;
          n_q <= cmd_i.degree;
          t_q <= cmd_i.t;
          u_q <= ParamOne - cmd_i.t;
          tpk_q <= ParamOne;
          upk_q <= ParamOne;
          tp_q[0] <= ParamOne;
          up_q[0] <= ParamOne;
          k_q <= 5'd1;
          i_q <= '0;
          ax_q <= '0; ay_q <= '0; az_q <= '0;
        end
        S_POW: begin
          if (k_q > {1'b0, n_q}) begin
            state_q <= S_BL0;
          end else begin
            tp_q[k_q[AW-1:0]] <= tprod[32:16];
            up_q[k_q[AW-1:0]] <= uprod[32:16];
            tpk_q <= tprod[32:16];
            upk_q <= uprod[32:16];
            k_q <= k_q + 5'd1;
          end
        end
        S_BL0: begin
          cb_q <= 30'(binom_tab[n_q][i_q]) * 30'(ti);
          state_q <= S_BL1;
        end
        S_BL1: begin
          blend_q <= bprod[32:16];
          last_q <= (i_q == n_q);
          state_q <= S_ACC;
        end
        S_ACC: begin
          ax_q <= ax_q + 41'(cx * $signed({1'b0, blend_q}));
          ay_q <= ay_q + 41'(cy * $signed({1'b0, blend_q}));
          az_q <= az_q + 41'(cz * $signed({1'b0, blend_q}));
          if (last_q) begin
            state_q <= S_DONE;
          end else begin
            i_q <= i_q + 4'd1;
            state_q <= S_BL0;
          end
        end
        S_DONE: if (!ov_q || out_ready_i) begin
          out_q.point_x <= sat(ax_q);
          out_q.point_y <= sat(ay_q);
          out_q.point_z <= sat(az_q);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(out_q)))
    else $error("result dropped while stalled");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (i_q <= n_q))
    else $error("point index past degree");
  a_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POW) |-> (k_q <= {1'b0, n_q} + 5'd1))
    else $error("power index overrun");
endmodule
`default_nettype wire

// ===== sv/bezier_curve_point_evaluator.sv =====
// Top level of the Bezier curve point evaluator (Bernstein sum, Q11.4 points).
// Depends on bcpe_pkg, bcpe_ram, bcpe_front, bcpe_back.
//
//  channel  | signals                         | moves
//  in       | in_valid_i/in_ready_o/in_data_i | load or evaluate item
//  out      | out_valid_o/out_ready_i/out_data_o | curve point item
//  cfg      | cfg_we_i/cfg_data_i             | curve_degree
//
// A load with an index up to the degree writes the store at its accepting edge, but is
// accepted only while no evaluation is queued or running. An evaluation waits in the
// front queue; the back end then takes it, builds the power tables, runs each control
// point through two blend products and an accumulate, and saturates the sum.
// A held result stalls the back end, fills the one-entry queue, then drops in_ready_o.
// Reset sets degree 5 and empties the queue and output register.
`default_nettype none
module bezier_curve_point_evaluator #(
  parameter int unsigned MaxPoints = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire bcpe_pkg::req_t            in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bcpe_pkg::rsp_t                 out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bcpe_pkg::DegW-1:0] cfg_data_i
);
  import bcpe_pkg::*;
  localparam int unsigned AW = $clog2(MaxPoints);

  logic [DegW-1:0] degree_q;
  logic we, cmd_valid, cmd_ready;
  logic [AW-1:0] waddr, raddr;
  logic [3*CoordW-1:0] wdata, rdata;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) degree_q <= 4'd5;
    else if (cfg_we_i) degree_q <= cfg_data_i;
  end

  bcpe_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .degree_i(degree_q), .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  bcpe_ram #(.Width(3*CoordW), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  bcpe_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .raddr_o(raddr), .rdata_i(rdata),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for bezier_curve_point_evaluator: loads control points,
// evaluates the curve at several degrees, and checks every point against an
// internal Bernstein-sum predictor. Depends on bcpe_pkg and the RTL only.
`timescale 1ns / 100ps
module testbench;
  import bcpe_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [DegW-1:0] cfg_data_i = '0;

  bezier_curve_point_evaluator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [DegW-1:0] degree_q;
  logic signed [CoordW-1:0] pts_x[16], pts_y[16], pts_z[16];
  rsp_t pending_points[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  bit gaps_on = 1'b1;
  bit timed_out = 1'b0;

  function automatic logic signed [CoordW-1:0] sat_coord(input longint signed acc);
    longint signed v;
    v = acc >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CoordW-1:0];
  endfunction

  function automatic rsp_t curve_point(input logic [ParamW-1:0] param);
    longint unsigned t, u, coef, blend;
    longint unsigned tp[16], up[16];
    longint signed ax, ay, az;
    int n;
    rsp_t r;
    n = degree_q;
    t = (param > ParamOne) ? 65536 : param;
    u = 65536 - t;
    tp[0] = 65536;
    up[0] = 65536;
    for (int k = 1; k <= n; k++) begin
      tp[k] = (tp[k-1] * t) >> 16;
      up[k] = (up[k-1] * u) >> 16;
    end
    coef = 1;
    ax = 0; ay = 0; az = 0;
    for (int i = 0; i <= n; i++) begin
      blend = (coef * tp[i] * up[n-i]) >> 16;
      ax += longint'(pts_x[i]) * longint'(blend);
      ay += longint'(pts_y[i]) * longint'(blend);
      az += longint'(pts_z[i]) * longint'(blend);
      coef = coef * longint'(n - i) / longint'(i + 1);
    end
    r.point_x = sat_coord(ax);
    r.point_y = sat_coord(ay);
    r.point_z = sat_coord(az);
    return r;
  endfunction

  function automatic int gap_len();
    if (!gaps_on || $urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    if (item.req_type == REQ_LOAD) begin
      if (item.point_index <= degree_q) begin
        pts_x[item.point_index] = item.coord_x;
        pts_y[item.point_index] = item.coord_y;
        pts_z[item.point_index] = item.coord_z;
      end
    end else begin
      pending_points.push_back(curve_point(item.curve_param));
    end
  endtask

  task automatic load_point(input int idx, input int x, input int y, input int z);
    req_t r;
    r = '0;
    r.req_type = REQ_LOAD;
    r.point_index = IdxW'(idx);
    r.coord_x = CoordW'(x); r.coord_y = CoordW'(y); r.coord_z = CoordW'(z);
    r.curve_param = ParamW'($urandom_range(0, 131071));
    send_item(r);
  endtask

  task automatic eval_at(input logic [ParamW-1:0] param);
    req_t r;
    r = '0;
    r.req_type = REQ_EVAL;
    r.point_index = IdxW'($urandom_range(0, 15));
    r.coord_x = CoordW'($urandom); r.coord_y = CoordW'($urandom);
    r.coord_z = CoordW'($urandom);
    r.curve_param = param;
    send_item(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_degree(input int deg);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= DegW'(deg);
    @(posedge clk_i);
    degree_q = DegW'(deg);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ParamW-1:0] rand_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return ParamOne;
      2: return ParamW'($urandom_range(65537, 131071));
      default: return ParamW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic test_reset_degree();
    for (int i = 0; i <= 5; i++) load_point(i, 100 * i, -50 * i, 7 * i);
    eval_at(17'd0);
    eval_at(17'd32768);
    eval_at(ParamOne);
  endtask

  task automatic test_directed();
    set_degree(15);
    for (int i = 0; i < 16; i++) load_point(i, 32767, -32768, (i % 2) ? 32767 : -32768);
    eval_at(17'd0);
    eval_at(ParamOne);
    eval_at(17'h1FFFF);
    eval_at(17'd32768);
    eval_at(17'd1);
    eval_at(17'd65535);
    set_degree(0);
    load_point(7, 1, 1, 1);
    load_point(0, -1, 0, 5);
    eval_at(17'd40000);
    set_degree(1);
    eval_at(17'd21845);
  endtask

  task automatic random_phase(input int deg, input int count);
    set_degree(deg);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 3)
        load_point($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
      else
        eval_at(rand_param());
    end
  endtask

  task automatic test_random();
    random_phase(12, 80);
    gaps_on = 1'b0;
    random_phase(3, 60);
    gaps_on = 1'b1;
    random_phase(7, 80);
    random_phase(15, 80);
    random_phase(1, 60);
  endtask

  task automatic test_backpressure();
    set_degree(4);
    hold_reqs++;
    for (int k = 0; k < 30; k++) eval_at(rand_param());
    drain();
  endtask

  // receiver: random stalls while gaps are on, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cycles <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 9) ? ($urandom_range(0, 3) != 0)
                                                : ($urandom_range(0, 3) == 0);
    end
  end

  always @(negedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", out_data_o);
      end else begin
        want = pending_points.pop_front();
        if (want.point_x !== out_data_o.point_x || want.point_y !== out_data_o.point_y ||
            want.point_z !== out_data_o.point_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     want.point_x, want.point_y, want.point_z,
                     out_data_o.point_x, out_data_o.point_y, out_data_o.point_z);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    degree_q = 4'd5;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_degree();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/bcpe_pkg.sv
sv/bcpe_ram.sv
sv/bcpe_front.sv
sv/bcpe_back.sv
sv/bezier_curve_point_evaluator.sv
tb/testbench.sv
